@@ hw/rtl/rlbe_pkg.sv @@
package rlbe_pkg;

	localparam int LED_COUNT       = 1;
	localparam int RLBE_FIFO_DEPTH = 4;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 48;
	localparam int ACT_W      = 3;
	localparam int CFG_IDX_W  = 1;

	localparam logic [7:0] SET_COLOR_LEN = 8'd5;
	localparam logic [7:0] GET_COLOR_LEN = 8'd2;
	localparam logic [7:0] LIGHT_MAX     = 8'd100;
	localparam logic [6:0] LIGHT_RESET   = 7'd100;

	localparam logic [7:0] ZERO_DUTY_RESET = 8'd29;
	localparam logic [7:0] ONE_DUTY_RESET  = 8'd58;

	localparam int DATA_BITS   = 24;
	localparam int FRAME_WORDS = 48;

	// floor(x / 100) equals (x * 5243) >> 19 for every x below 43690.
	localparam int SCALE_RECIP = 5243;
	localparam int SCALE_SHIFT = 19;

	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_DUTY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_DUTY  = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_SET_COLOR = 3'd0,
		ACT_GET_COLOR = 3'd1,
		ACT_SET_LIGHT = 3'd2,
		ACT_GET_LIGHT = 3'd3,
		ACT_UPDATE    = 3'd4
	} action_t;

	typedef struct packed {
		logic        is_frame;
		logic [1:0]  cmd;
		logic        status;
		logic        has_color;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [6:0]  light;
		logic        save;
		logic [DATA_BITS-1:0] bits;
	} entry_t;

endpackage

@@ hw/rtl/rlbe_front.sv @@
module rlbe_front import rlbe_pkg::*; #(
	parameter int DEPTH = RLBE_FIFO_DEPTH,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [ACT_W-1:0]     s_tuser,
	input  logic [CNT_W-1:0]     fifo_count,
	output logic                 push,
	output entry_t               push_entry
);

	logic       accept;
	logic [7:0] led_index, led_count, cmd_length, red_in, green_in, blue_in, light_in;
	logic       save_flag, addr_ok;
	action_t    act;

	logic [7:0] red_q, green_q, blue_q;
	logic [6:0] bright_q, saved_q;
	logic       pending_q;

	logic [7:0] red_d, green_d, blue_d;
	logic [6:0] bright_d, saved_d;
	logic       pending_d;
	logic       emit, is_frame;
	entry_t     rep;

	logic       v_s1, frame_s1;
	entry_t     rep_s1;
	logic [7:0] g_s1, r_s1, b_s1;
	logic [6:0] br_s1;

	logic        v_s2, frame_s2;
	entry_t      rep_s2;
	logic [14:0] pg_s2, pr_s2, pb_s2;
	logic [27:0] qg, qr, qb;

	logic [CNT_W:0] used;

	assign led_index  = s_tdata[7:0];
	assign led_count  = s_tdata[15:8];
	assign cmd_length = s_tdata[23:16];
	assign red_in     = s_tdata[31:24];
	assign green_in   = s_tdata[39:32];
	assign blue_in    = s_tdata[47:40];
	assign light_in   = s_tdata[55:48];
	assign save_flag  = s_tdata[56];
	assign act        = action_t'(s_tuser);
	assign addr_ok    = (led_index == 8'd0) && (led_count == 8'(LED_COUNT));

	// Slots already promised to requests still in the pipeline count as taken.
	assign used     = {1'b0, fifo_count} + (CNT_W + 1)'(v_s1) + (CNT_W + 1)'(v_s2);
	assign s_tready = used < (CNT_W + 1)'(DEPTH);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		red_d     = red_q;
		green_d   = green_q;
		blue_d    = blue_q;
		bright_d  = bright_q;
		saved_d   = saved_q;
		pending_d = pending_q;
		emit      = 1'b0;
		is_frame  = 1'b0;
		rep       = '0;
		rep.cmd   = s_tuser[1:0];
		unique case (act)
			ACT_SET_COLOR: begin
				emit = 1'b1;
				if (addr_ok && cmd_length == SET_COLOR_LEN) begin
					red_d     = red_in;
					green_d   = green_in;
					blue_d    = blue_in;
					pending_d = 1'b1;
				end else begin
					rep.status = 1'b1;
				end
			end
			ACT_GET_COLOR: begin
				emit = 1'b1;
				if (addr_ok && cmd_length == GET_COLOR_LEN) begin
					rep.has_color = 1'b1;
					rep.red       = red_q;
					rep.green     = green_q;
					rep.blue      = blue_q;
				end else begin
					rep.status = 1'b1;
				end
			end
			ACT_SET_LIGHT: begin
				emit      = 1'b1;
				rep.light = bright_q;
				if (light_in <= LIGHT_MAX) begin
					rep.light = light_in[6:0];
					if (save_flag && light_in != {1'b0, saved_q}) begin
						saved_d  = light_in[6:0];
						rep.save = 1'b1;
					end
					if (light_in != {1'b0, bright_q}) begin
						bright_d  = light_in[6:0];
						pending_d = 1'b1;
					end
				end else begin
					rep.status = 1'b1;
				end
			end
			ACT_GET_LIGHT: begin
				emit      = 1'b1;
				rep.light = bright_q;
			end
			ACT_UPDATE: begin
				if (pending_q) begin
					emit      = 1'b1;
					is_frame  = 1'b1;
					pending_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q     <= 8'd0;
			green_q   <= 8'd0;
			blue_q    <= 8'd0;
			bright_q  <= LIGHT_RESET;
			saved_q   <= LIGHT_RESET;
			pending_q <= 1'b1;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			if (accept) begin
				red_q     <= red_d;
				green_q   <= green_d;
				blue_q    <= blue_d;
				bright_q  <= bright_d;
				saved_q   <= saved_d;
				pending_q <= pending_d;
			end
			v_s1 <= accept && emit;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		frame_s1 <= is_frame;
		rep_s1   <= rep;
		g_s1     <= green_q;
		r_s1     <= red_q;
		b_s1     <= blue_q;
		br_s1    <= bright_q;
		frame_s2 <= frame_s1;
		rep_s2   <= rep_s1;
		pg_s2    <= 15'(g_s1) * 15'(br_s1);
		pr_s2    <= 15'(r_s1) * 15'(br_s1);
		pb_s2    <= 15'(b_s1) * 15'(br_s1);
	end

	assign qg = 28'(pg_s2) * 28'(SCALE_RECIP);
	assign qr = 28'(pr_s2) * 28'(SCALE_RECIP);
	assign qb = 28'(pb_s2) * 28'(SCALE_RECIP);

	always_comb begin
		push_entry = rep_s2;
		if (frame_s2) begin
			push_entry          = '0;
			push_entry.is_frame = 1'b1;
			push_entry.bits     = {qg[SCALE_SHIFT +: 8], qr[SCALE_SHIFT +: 8],
				qb[SCALE_SHIFT +: 8]};
		end
	end

	assign push = v_s2;

endmodule

@@ hw/rtl/rlbe_fifo.sv @@
module rlbe_fifo import rlbe_pkg::*; #(
	parameter int DEPTH = RLBE_FIFO_DEPTH,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int PTR_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  entry_t           push_entry,
	input  logic             pop,
	output entry_t           head,
	output logic             empty,
	output logic [CNT_W-1:0] count
);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

@@ hw/rtl/rlbe_back.sv @@
module rlbe_back import rlbe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]            cfg_data,
	input  entry_t                head,
	input  logic                  empty,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser,
	output logic                  m_tlast
);

	localparam int WCNT_W = $clog2(FRAME_WORDS);
	localparam int BIT_W  = $clog2(DATA_BITS);

	logic [7:0]        zero_duty_q, one_duty_q;
	logic [WCNT_W-1:0] word_q;
	logic              m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic              load, word_end, bit_val;
	logic [BIT_W-1:0]  bit_idx;
	logic [7:0]        duty;
	logic [OUT_DATA_W-1:0] word_data, reply_data;

	assign cfg_ready = 1'b1;

	assign load     = !m_tvalid_q || m_tready;
	assign word_end = (word_q == WCNT_W'(FRAME_WORDS - 1));
	assign pop      = load && !empty && (!head.is_frame || word_end);

	// Data words walk the colour bits from the most significant down.
	assign bit_idx = BIT_W'(DATA_BITS - 1) - word_q[BIT_W-1:0];
	assign bit_val = head.bits[bit_idx];

	always_comb begin
		duty = 8'd0;
		if (word_q < WCNT_W'(DATA_BITS)) begin
			duty = bit_val ? one_duty_q : zero_duty_q;
		end
	end

	assign word_data  = {4'b0, duty, 36'b0};
	assign reply_data = {4'b0, 8'd0, head.save, head.light, head.blue, head.green,
		head.red, head.has_color, head.status, head.cmd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_duty_q <= ZERO_DUTY_RESET;
			one_duty_q  <= ONE_DUTY_RESET;
			word_q      <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_ZERO_DUTY: zero_duty_q <= cfg_data;
					CFG_ONE_DUTY:  one_duty_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (load) begin
				m_tvalid_q <= !empty;
				if (!empty && head.is_frame) begin
					word_q <= word_end ? '0 : word_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			m_tdata_q <= head.is_frame ? word_data : reply_data;
			m_tuser_q <= head.is_frame;
			m_tlast_q <= head.is_frame && word_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

@@ hw/rtl/rgb_led_command_and_bit_encoder_top.sv @@
// Command controller and bit encoder for one addressable RGB LED.
// Requests enter on the s_ channel: s_tuser carries the action, s_tdata the command
// bytes, colour, brightness and save flag. Results leave on the m_ channel: m_tuser
// is 0 for a command reply and 1 for a duty word, m_tlast marks the last duty word.
// The cfg channel writes the duty values for a zero bit (index 0) and a one bit
// (index 1) and is always ready; the user must write it only while the block is
// idle, which the block does not enforce. A front stage decodes each request,
// updates the colour and brightness and, for an update, scales the colour over
// two multiplier stages; a small queue then feeds the back stage, which drives
// the output register. A result passes the front stage registers s1 and s2, the
// queue and the output register before it becomes valid.
// Throughput: one request per cycle while the queue has room. A reply is one output
// word; an update with a change pending sends 48 duty words from the back stage
// counter, one per cycle while the receiver is ready, and the front stalls once
// the queue is full. When the receiver stalls, the output word holds and requests
// keep entering until the queue is full. After reset the colour is black, brightness
// is 100 and an update is pending, so an update before any colour set sends a black frame.
module rgb_led_command_and_bit_encoder_top import rlbe_pkg::*; #(
	parameter int FIFO_DEPTH = RLBE_FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // led_index, led_count, cmd_length, red_in,
	                                         // green_in, blue_in, light_in, save_flag
	input  logic [ACT_W-1:0]      s_tuser,   // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // reply_command, status, has_color, red_out,
	                                         // green_out, blue_out, light_out,
	                                         // save_request, duty_word
	output logic                  m_tuser,   // result_kind
	output logic                  m_tlast,   // last
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]            cfg_data
);

	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic             push, pop, empty;
	entry_t           push_entry, head;
	logic [CNT_W-1:0] fifo_count;

	rlbe_front #(.DEPTH(FIFO_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.fifo_count (fifo_count),
		.push       (push),
		.push_entry (push_entry)
	);

	rlbe_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.count      (fifo_count)
	);

	rlbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	a_last_is_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("end of frame marked on a reply");

	a_reply_no_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[43:36] == 8'd0)
		else $error("reply carries a duty value");

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= CNT_W'(FIFO_DEPTH))
		else $error("queue count beyond its depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> fifo_count < CNT_W'(FIFO_DEPTH))
		else $error("write into a full queue");

endmodule
